@@ hw/rtl/srrm_pkg.sv @@
// srrm_pkg: shared widths, command and register codes, reset values and the
// structs that pass between the scroll ring rate matcher modules.
// No dependencies.
package srrm_pkg;

   // field and datapath widths
   localparam int LINE_W     = 13;
   localparam int CMD_W      = 2;
   localparam int RATE_W     = 16;
   localparam int JSUM_W     = 18;
   localparam int CREDIT_W   = 24;
   localparam int PEND_W     = 8;
   localparam int DRAW_W     = 10;
   localparam int DIV_DW     = 14;
   localparam int DIV_SW     = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 72;

   // commands
   localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SKIP  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_LINES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JITTER       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FPF          = 2'd3;

   // reset values and fixed-point constants
   localparam logic [LINE_W-1:0]   SCREEN_LINES_RST = 13'd1000;
   localparam logic [RATE_W-1:0]   FPF_RST          = 16'd256;
   localparam logic [JSUM_W-1:0]   JSUM_MAX         = 18'h3FFFF;
   localparam logic [JSUM_W-1:0]   ONE_Q16          = 18'h10000;
   localparam logic [CREDIT_W:0]   CREDIT_DEC       = 25'h1FFFF00;
   localparam logic [CREDIT_W-1:0] CREDIT_MAX       = 24'h7FFFFF;
   localparam logic [CREDIT_W-1:0] CREDIT_MIN       = 24'h800000;
   localparam int                  WARN_FACTOR      = 10;

   typedef struct packed {
      logic [LINE_W-1:0] screen_lines;
      logic [RATE_W-1:0] scroll_rate;
      logic [RATE_W-1:0] jitter_amount;
      logic [RATE_W-1:0] frames_per_feed;
   } srrm_cfg_type;

   typedef struct packed {
      logic              take;
      logic [CMD_W-1:0]  cmd;
      logic [LINE_W-1:0] frame_lines;
   } srrm_item_type;

   typedef struct packed {
      logic              go;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_SW-1:0] divisor;
   } srrm_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_DW-1:0] quot;
      logic [DIV_SW-1:0] rem;
   } srrm_div_rsp_type;

   // last member lands in the lowest bits
   typedef struct packed {
      logic              ready_res;
      logic              skip_now;
      logic              backlog_warning;
      logic [PEND_W-1:0] frames_pending;
      logic              draw_ok;
      logic              wrapped;
      logic              line_skipped;
      logic [LINE_W-1:0] first_part;
      logic [LINE_W-1:0] line_count;
      logic [LINE_W-1:0] seg_end;
      logic [LINE_W-1:0] seg_start;
   } srrm_result_type;

endpackage

@@ hw/rtl/srrm_div.sv @@
// srrm_div: shared restoring divider, one quotient bit per cycle.
// Serves every modulo by the ring length and the backlog division.
// Depends on srrm_pkg.
module srrm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  srrm_pkg::srrm_div_req_type div_req,
   output srrm_pkg::srrm_div_rsp_type div_rsp
);
   import srrm_pkg::*;

   localparam int CNT_W = $clog2(DIV_DW);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_DW - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_SW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_SW-1:0] dsr_ff, dsr_in;

   logic [DIV_SW:0]   shifted;
   logic [DIV_SW+1:0] diff;
   logic              ge;

   // trial subtract of the divisor from the shifted partial remainder
   assign shifted = {rem_ff, quo_ff[DIV_DW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};
   assign ge      = ~diff[DIV_SW+1];

   // load on go, then shift one quotient bit in per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_SW-1:0] : shifted[DIV_SW-1:0];
         quo_in = {quo_ff[DIV_DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

@@ hw/rtl/srrm_seq.sv @@
// srrm_seq: command sequencer with the ring indexes, jitter sums and draw
// credit; issues modulo and division jobs to the shared divider.
// Depends on srrm_pkg.
module srrm_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  srrm_pkg::srrm_cfg_type     cfg,
   input  srrm_pkg::srrm_item_type    item,
   output logic                       idle,
   input  logic                       out_free,
   output logic                       push,
   output srrm_pkg::srrm_result_type  result,
   output srrm_pkg::srrm_div_req_type div_req,
   input  srrm_pkg::srrm_div_rsp_type div_rsp
);
   import srrm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_F_START,
      S_F_CALC,
      S_F_END,
      S_D_WI,
      S_D_RI,
      S_D_BL,
      S_D_DIV,
      S_D_SEL,
      S_D_END,
      S_FIN,
      S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [LINE_W-1:0]   lines_ff, lines_in;
   logic [LINE_W-1:0]   w_ff, w_in;
   logic [LINE_W-1:0]   start_ff, start_in;
   logic [LINE_W-1:0]   ri_ff, ri_in;
   logic [LINE_W-1:0]   backlog_ff, backlog_in;
   logic [LINE_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [LINE_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [JSUM_W-1:0]   fsum_ff, fsum_in;
   logic [JSUM_W-1:0]   dsum_ff, dsum_in;
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   srrm_result_type     res_ff, res_in;
   srrm_div_req_type    div_req_ff, div_req_in;

   logic [LINE_W-1:0]   ring_len;
   logic [DIV_SW-1:0]   ring_div;
   logic [DIV_DW-1:0]   w14;
   logic                credit_two;
   logic [LINE_W-1:0]   e_mod, e_next;

   // frame arithmetic
   logic [DIV_DW-1:0]   f_sum, f_end_raw, f_end;
   logic                f_full, f_wrap, f_skip;
   logic [JSUM_W-1:0]   fsum_add;

   // draw arithmetic
   logic [LINE_W-1:0]   d_backlog;
   logic [JSUM_W-1:0]   dsum_add;
   logic [7:0]          rate;
   logic [DRAW_W-1:0]   d_draw;
   logic                d_take;
   logic [DIV_DW-1:0]   d_reach, d_end_raw, d_end;
   logic                d_wrap;
   logic [LINE_W-1:0]   warn_lim;

   // credit arithmetic
   logic [CREDIT_W:0]   credit_delta, credit_sum;

   function automatic logic [JSUM_W-1:0] jsum_add(input logic [JSUM_W-1:0] a,
                                                  input logic [RATE_W-1:0] b);
      logic [JSUM_W:0] s;
      s = {1'b0, a} + {{(JSUM_W+1-RATE_W){1'b0}}, b};
      return s[JSUM_W] ? JSUM_MAX : s[JSUM_W-1:0];
   endfunction

   // ring length, zero acts as one
   assign ring_len   = (cfg.screen_lines == '0) ? LINE_W'(1) : cfg.screen_lines;
   assign ring_div   = {{(DIV_SW-LINE_W){1'b0}}, ring_len};
   assign w14        = {{(DIV_DW-LINE_W){1'b0}}, w_ff};
   assign credit_two = ~credit_ff[CREDIT_W-1] && (credit_ff[CREDIT_W-2:9] != '0);

   // segment end reduced by the divider, and the index just after it
   assign e_mod  = div_rsp.rem[LINE_W-1:0];
   assign e_next = (e_mod == w_ff - LINE_W'(1)) ? '0 : e_mod + LINE_W'(1);

   // frame: fill, wrap and jitter skip
   always_comb begin
      f_sum     = {1'b0, start_ff} + {1'b0, lines_ff};
      f_full    = f_sum >= w14;
      f_wrap    = f_sum > w14;
      fsum_add  = jsum_add(fsum_ff, cfg.jitter_amount);
      f_skip    = f_wrap && (fsum_add >= ONE_Q16);
      f_end_raw = f_sum - DIV_DW'(1) - (f_wrap ? w14 : '0);
      if (f_skip) begin
         f_end = (f_end_raw == '0) ? w14 - DIV_DW'(1) : f_end_raw - DIV_DW'(1);
      end else begin
         f_end = f_end_raw;
      end
   end

   // draw: backlog, line count choice and segment end
   always_comb begin
      d_backlog = (start_ff >= ri_ff) ? start_ff - ri_ff : start_ff + w_ff - ri_ff;
      dsum_add  = jsum_add(dsum_ff, {cfg.scroll_rate[7:0], 8'h00});
      rate      = cfg.scroll_rate[RATE_W-1:8];
      d_take    = 1'b0;
      if (backlog_ff > {4'b0000, rate, 1'b0}) begin
         d_draw = {1'b0, rate, 1'b0};
      end else if (backlog_ff > {5'b00000, rate}) begin
         d_take = dsum_ff >= ONE_Q16;
         d_draw = {2'b00, rate} + {{(DRAW_W-1){1'b0}}, d_take};
      end else begin
         d_draw = backlog_ff[DRAW_W-1:0];
      end
      d_reach   = {1'b0, ri_ff} + {{(DIV_DW-DRAW_W){1'b0}}, d_draw};
      d_wrap    = d_reach > w14;
      d_end_raw = d_reach - DIV_DW'(1);
      d_end     = d_wrap ? d_end_raw - w14 : d_end_raw;
      warn_lim  = LINE_W'(WARN_FACTOR) * {5'b00000, rate};
   end

   // saturating credit update
   always_comb begin
      credit_delta = '0;
      case (cmd_ff)
         CMD_FRAME: credit_delta = {{(CREDIT_W+1-RATE_W){1'b0}}, cfg.frames_per_feed};
         CMD_DRAW:  credit_delta = res_ff.draw_ok ? CREDIT_DEC : '0;
         CMD_SKIP:  credit_delta = credit_two ? CREDIT_DEC : '0;
         default:   credit_delta = '0;
      endcase
      credit_sum = {credit_ff[CREDIT_W-1], credit_ff} + credit_delta;
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      lines_in        = lines_ff;
      w_in            = w_ff;
      start_in        = start_ff;
      ri_in           = ri_ff;
      backlog_in      = backlog_ff;
      wr_idx_in       = wr_idx_ff;
      rd_idx_in       = rd_idx_ff;
      fsum_in         = fsum_ff;
      dsum_in         = dsum_ff;
      credit_in       = credit_ff;
      res_in          = res_ff;
      div_req_in      = div_req_ff;
      div_req_in.go   = 1'b0;
      push            = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (item.take) begin
               cmd_in   = item.cmd;
               lines_in = item.frame_lines;
               w_in     = ring_len;
               res_in   = '0;
               unique case (item.cmd)
                  CMD_FRAME: begin
                     div_req_in.go       = 1'b1;
                     div_req_in.dividend = {{(DIV_DW-LINE_W){1'b0}}, wr_idx_ff};
                     div_req_in.divisor  = ring_div;
                     state_in            = S_F_START;
                  end
                  CMD_DRAW: begin
                     div_req_in.go       = 1'b1;
                     div_req_in.dividend = {{(DIV_DW-LINE_W){1'b0}}, wr_idx_ff};
                     div_req_in.divisor  = ring_div;
                     state_in            = S_D_WI;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_F_START: begin
            if (div_rsp.done) begin
               start_in = e_mod;
               state_in = S_F_CALC;
            end
         end
         S_F_CALC: begin
            if (f_full) begin
               fsum_in = f_skip ? fsum_add - ONE_Q16 : fsum_add;
            end
            res_in.seg_start    = start_ff;
            res_in.line_count   = f_skip ? lines_ff - LINE_W'(1) : lines_ff;
            res_in.first_part   = f_wrap ? w_ff - start_ff : '0;
            res_in.line_skipped = f_skip;
            res_in.wrapped      = f_wrap;
            if (lines_ff == '0) begin
               res_in.seg_end = start_ff;
               wr_idx_in      = start_ff;
               state_in       = S_FIN;
            end else begin
               div_req_in.go       = 1'b1;
               div_req_in.dividend = f_end;
               div_req_in.divisor  = {{(DIV_SW-LINE_W){1'b0}}, w_ff};
               state_in            = S_F_END;
            end
         end
         S_F_END: begin
            if (div_rsp.done) begin
               res_in.seg_end = e_mod;
               wr_idx_in      = e_next;
               state_in       = S_FIN;
            end
         end
         S_D_WI: begin
            if (div_rsp.done) begin
               start_in            = e_mod;
               div_req_in.go       = 1'b1;
               div_req_in.dividend = {{(DIV_DW-LINE_W){1'b0}}, rd_idx_ff};
               div_req_in.divisor  = {{(DIV_SW-LINE_W){1'b0}}, w_ff};
               state_in            = S_D_RI;
            end
         end
         S_D_RI: begin
            if (div_rsp.done) begin
               ri_in    = e_mod;
               state_in = S_D_BL;
            end
         end
         S_D_BL: begin
            dsum_in = dsum_add;
            if (credit_two) begin
               div_req_in.go       = 1'b1;
               div_req_in.dividend = {{(DIV_DW-LINE_W){1'b0}}, d_backlog};
               div_req_in.divisor  = credit_ff[CREDIT_W-2:8];
               state_in            = S_D_DIV;
            end else begin
               backlog_in = d_backlog;
               state_in   = S_D_SEL;
            end
         end
         S_D_DIV: begin
            if (div_rsp.done) begin
               backlog_in = div_rsp.quot[LINE_W-1:0];
               state_in   = S_D_SEL;
            end
         end
         S_D_SEL: begin
            if (d_draw == '0) begin
               res_in.seg_start = ri_ff;
               res_in.seg_end   = ri_ff;
               rd_idx_in        = ri_ff;
               state_in         = S_FIN;
            end else begin
               if (d_take) begin
                  dsum_in = dsum_ff - ONE_Q16;
               end
               res_in.seg_start       = d_wrap ? '0 : ri_ff;
               res_in.line_count      = {{(LINE_W-DRAW_W){1'b0}}, d_draw};
               res_in.wrapped         = d_wrap;
               res_in.draw_ok         = 1'b1;
               res_in.backlog_warning = backlog_ff > warn_lim;
               div_req_in.go          = 1'b1;
               div_req_in.dividend    = d_end;
               div_req_in.divisor     = {{(DIV_SW-LINE_W){1'b0}}, w_ff};
               state_in               = S_D_END;
            end
         end
         S_D_END: begin
            if (div_rsp.done) begin
               res_in.seg_end = e_mod;
               rd_idx_in      = e_next;
               state_in       = S_FIN;
            end
         end
         S_FIN: begin
            if (cmd_ff == CMD_SKIP) begin
               res_in.skip_now = credit_two;
            end
            if (credit_sum[CREDIT_W] != credit_sum[CREDIT_W-1]) begin
               credit_in = credit_sum[CREDIT_W] ? CREDIT_MIN : CREDIT_MAX;
            end else begin
               credit_in = credit_sum[CREDIT_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         fsum_ff       <= '0;
         dsum_ff       <= '0;
         credit_ff     <= '0;
         div_req_ff.go <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         fsum_ff       <= fsum_in;
         dsum_ff       <= dsum_in;
         credit_ff     <= credit_in;
         div_req_ff.go <= div_req_in.go;
      end
      cmd_ff              <= cmd_in;
      lines_ff            <= lines_in;
      w_ff                <= w_in;
      start_ff            <= start_in;
      ri_ff               <= ri_in;
      backlog_ff          <= backlog_in;
      res_ff              <= res_in;
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
   end

   // status fields come from the credit as it stands after the transaction
   always_comb begin
      result = res_ff;
      if (credit_ff[CREDIT_W-1]) begin
         result.frames_pending = '0;
      end else if (credit_ff[CREDIT_W-2:16] != '0) begin
         result.frames_pending = '1;
      end else begin
         result.frames_pending = credit_ff[15:8];
      end
      result.ready_res = ~credit_ff[CREDIT_W-1] && (credit_ff[CREDIT_W-2:8] != '0);
   end

   assign idle    = (state_ff == S_IDLE);
   assign div_req = div_req_ff;

endmodule

@@ hw/rtl/scroll_ring_rate_matcher_core.sv @@
// scroll_ring_rate_matcher_core: top level of the scrolling line ring rate
// matcher. Holds the configuration registers and the result register.
// Depends on srrm_pkg, srrm_seq and srrm_div.
//
// Usage:
//   req_ channel takes one command per transaction: req_tuser carries the
//   command (frame arrives, draw tick, skip check) and req_tdata the line
//   count of an arriving frame. rsp_ channel returns exactly one result
//   transaction per command. csr_ writes the four registers (ring length,
//   scroll rate, jitter amount, frames per feed); the user must write them
//   only while no command is open, as the block does not enforce it.
//   Every modulo by the ring length and the backlog division run on one
//   shared 14-step restoring divider; a skip check or unknown command
//   uses no divider job. The sequencer goes idle, ready for the next
//   command, as the result enters the result register; the block takes
//   one command at a time.
//   When the receiver stalls, the result waits in the result register and
//   one more command may run to completion behind it, then it holds.
//   Reset (synchronous) clears indexes, jitter sums and credit and loads the
//   register defaults: ring of 1000 lines, credit of one frame per feed.
module scroll_ring_rate_matcher_core (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [srrm_pkg::REQ_DATA_W-1:0]     req_tdata,  // [12:0] frame_lines
   input  logic [srrm_pkg::CMD_W-1:0]          req_tuser,  // [1:0] cmd
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [12:0] seg_start, [25:13] seg_end, [38:26] line_count, [51:39] first_part,
   // [52] line_skipped, [53] wrapped, [54] draw_ok, [62:55] frames_pending,
   // [63] backlog_warning, [64] skip_now, [65] ready_res
   output logic [srrm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // configuration write port
   input  logic                                csr_we,
   input  logic [srrm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srrm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import srrm_pkg::*;

   srrm_cfg_type     cfg_ff, cfg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   srrm_result_type  rsp_data_ff, rsp_data_in;

   srrm_item_type    item;
   logic             seq_idle;
   logic             out_free;
   logic             push;
   srrm_result_type  result;
   srrm_div_req_type div_req;
   srrm_div_rsp_type div_rsp;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_LINES: cfg_in.screen_lines    = csr_wdata[LINE_W-1:0];
            CSR_SCROLL_RATE:  cfg_in.scroll_rate     = csr_wdata[RATE_W-1:0];
            CSR_JITTER:       cfg_in.jitter_amount   = csr_wdata[RATE_W-1:0];
            CSR_FPF:          cfg_in.frames_per_feed = csr_wdata[RATE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // accept a command only while the sequencer is idle
   assign req_tready       = seq_idle;
   assign item.take        = req_tvalid && req_tready;
   assign item.cmd         = req_tuser;
   assign item.frame_lines = req_tdata[LINE_W-1:0];

   // result register: drain on handshake, load on push
   assign out_free = ~rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_lines    <= SCREEN_LINES_RST;
         cfg_ff.scroll_rate     <= '0;
         cfg_ff.jitter_amount   <= '0;
         cfg_ff.frames_per_feed <= FPF_RST;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-$bits(srrm_result_type)){1'b0}}, rsp_data_ff};

   srrm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .item     (item),
      .idle     (seq_idle),
      .out_free (out_free),
      .push     (push),
      .result   (result),
      .div_req  (div_req),
      .div_rsp  (div_rsp)
   );

   srrm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

@@ verif/tb_scroll_ring_rate_matcher_core.sv @@
// tb_scroll_ring_rate_matcher_core: self-checking bench for the scroll ring rate matcher.
// Runs directed frame, draw and skip commands, then random ones under random flow control.
// A local model of the line ring predicts each result. Depends on srrm_pkg and the core.
module tb_scroll_ring_rate_matcher_core;
   import srrm_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_REPORTS   = 10;

   // fixed-point limits of the ring model
   localparam int UNIT_Q16      = 65536;
   localparam int UNIT_Q8       = 256;
   localparam int JSUM_CAP      = 'h3FFFF;
   localparam int CREDIT_TOP    = 8388607;
   localparam int CREDIT_BOTTOM = -8388608;
   localparam int WARN_RATIO    = 10;

   localparam srrm_result_type NO_FIELDS  = '0;
   localparam srrm_result_type ONE_CREDIT =
      '{ready_res: 1'b1, frames_pending: 8'd1, default: '0};

   // one row of the directed part: a register write or a command
   typedef struct packed {
      logic                 reg_write;
      logic [1:0]           code;      // register index or command
      logic [15:0]          value;     // register value or frame lines
      logic                 fixed;     // result given below
      srrm_result_type      result;
   } step_row_type;

   localparam int PLAN_LEN = 35;
   localparam step_row_type PLAN [PLAN_LEN] = '{
      // state right after reset
      '{1'b0, CMD_SKIP,         16'd0,    1'b1, NO_FIELDS},
      '{1'b0, CMD_UNKNOWN,      16'd0,    1'b1, NO_FIELDS},
      '{1'b0, CMD_DRAW,         16'd0,    1'b1, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd0,    1'b1, ONE_CREDIT},
      // frame far longer than the ring
      '{1'b0, CMD_FRAME,        16'd8191, 1'b0, NO_FIELDS},
      '{1'b1, CSR_JITTER,       16'hFFFF, 1'b0, NO_FIELDS},
      // wrap, stop one line short of the ring end, two wraps with a dropped line, short frame
      '{1'b0, CMD_FRAME,        16'd900,  1'b0, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd908,  1'b0, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd1001, 1'b0, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd999,  1'b0, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd2,    1'b0, NO_FIELDS},
      '{1'b1, CSR_SCROLL_RATE,  16'hFFFF, 1'b0, NO_FIELDS},
      // draws with the backlog divided by the credit
      '{1'b0, CMD_FRAME,        16'd500,  1'b0, NO_FIELDS},
      '{1'b0, CMD_DRAW,         16'd0,    1'b0, NO_FIELDS},
      '{1'b0, CMD_DRAW,         16'd0,    1'b0, NO_FIELDS},
      '{1'b0, CMD_SKIP,         16'd0,    1'b0, NO_FIELDS},
      // ring length of zero
      '{1'b1, CSR_SCREEN_LINES, 16'd0,    1'b0, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd5,    1'b0, NO_FIELDS},
      '{1'b0, CMD_DRAW,         16'd0,    1'b0, NO_FIELDS},
      // largest ring
      '{1'b1, CSR_SCREEN_LINES, 16'd8191, 1'b0, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd8191, 1'b0, NO_FIELDS},
      '{1'b0, CMD_DRAW,         16'd0,    1'b0, NO_FIELDS},
      // ring shrinks to 16 lines
      '{1'b1, CSR_SCREEN_LINES, 16'd16,   1'b0, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd3,    1'b0, NO_FIELDS},
      '{1'b0, CMD_DRAW,         16'd0,    1'b0, NO_FIELDS},
      '{1'b1, CSR_FPF,          16'd0,    1'b0, NO_FIELDS},
      '{1'b0, CMD_SKIP,         16'd0,    1'b0, NO_FIELDS},
      // fractional scroll rate with jitter carry
      '{1'b1, CSR_FPF,          16'h0100, 1'b0, NO_FIELDS},
      '{1'b1, CSR_SCROLL_RATE,  16'h0280, 1'b0, NO_FIELDS},
      '{1'b1, CSR_JITTER,       16'h8000, 1'b0, NO_FIELDS},
      '{1'b1, CSR_SCREEN_LINES, 16'd40,   1'b0, NO_FIELDS},
      '{1'b0, CMD_FRAME,        16'd12,   1'b0, NO_FIELDS},
      '{1'b0, CMD_DRAW,         16'd0,    1'b0, NO_FIELDS},
      '{1'b0, CMD_DRAW,         16'd0,    1'b0, NO_FIELDS},
      '{1'b0, CMD_UNKNOWN,      16'd0,    1'b0, NO_FIELDS}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [12:0] frame_lines
   logic [CMD_W-1:0]      req_tuser;   // [1:0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [12:0] seg_start, [25:13] seg_end, [38:26] line_count, [51:39] first_part,
   // [52] line_skipped, [53] wrapped, [54] draw_ok, [62:55] frames_pending,
   // [63] backlog_warning, [64] skip_now, [65] ready_res
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // model copy of registers and ring state
   logic [LINE_W-1:0] cfg_lines;
   logic [RATE_W-1:0] cfg_rate;
   logic [RATE_W-1:0] cfg_jitter;
   logic [RATE_W-1:0] cfg_fpf;
   int                wr_idx;
   int                rd_idx;
   int                feed_jsum;
   int                draw_jsum;
   int                credit;

   srrm_result_type   pending_results [$];
   int                cmds_issued;
   int                results_seen;
   int                mismatch_count;
   int                cycle_count;
   int                send_idle_pct;
   int                recv_stall_pct;
   bit                hold_request;

   scroll_ring_rate_matcher_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int add_sat(int a, int b);
      return (a + b > JSUM_CAP) ? JSUM_CAP : a + b;
   endfunction

   function automatic void add_credit(int delta);
      int c;
      c = credit + delta;
      if (c > CREDIT_TOP) c = CREDIT_TOP;
      if (c < CREDIT_BOTTOM) c = CREDIT_BOTTOM;
      credit = c;
   endfunction

   // advance the ring state by one command and return its result
   function automatic srrm_result_type advance_ring(logic [1:0] cmd, logic [12:0] lines);
      srrm_result_type r;
      int ring, start, last, n, nxt, first, whole, backlog, cnt, wi, ri, pend;
      bit wrap, skip;
      r = '0;
      ring = (cfg_lines == 0) ? 1 : int'(cfg_lines);
      wrap = 1'b0;
      skip = 1'b0;
      case (cmd)
         CMD_FRAME: begin
            start = wr_idx % ring;
            n = int'(lines);
            last = start + n - 1;
            first = 0;
            // wrap: add jitter, drop one line once it carries
            if (last > ring - 1) begin
               last -= ring;
               wrap = 1'b1;
               first = ring - start;
               feed_jsum = add_sat(feed_jsum, int'(cfg_jitter));
               if (feed_jsum >= UNIT_Q16) begin
                  feed_jsum -= UNIT_Q16;
                  skip = 1'b1;
                  if (n > 0) n--;
                  last = (last == 0) ? ring - 1 : last - 1;
               end
            end
            nxt = last + 1;
            if (nxt > ring - 1 && !wrap) feed_jsum = add_sat(feed_jsum, int'(cfg_jitter));
            if (nxt < 0) nxt = 0;
            wr_idx = nxt % ring;
            if (last < 0 || n == 0) last = start;
            add_credit(int'(cfg_fpf));
            r.seg_start    = LINE_W'(start);
            r.seg_end      = LINE_W'(last % ring);
            r.line_count   = LINE_W'(n);
            r.first_part   = LINE_W'(first);
            r.line_skipped = skip;
            r.wrapped      = wrap;
         end
         CMD_DRAW: begin
            wi = wr_idx % ring;
            ri = rd_idx % ring;
            whole = int'(cfg_rate[15:8]);
            draw_jsum = add_sat(draw_jsum, int'(cfg_rate[7:0]) << 8);
            backlog = (wi >= ri) ? wi - ri : wi + ring - ri;
            if (credit >= 2 * UNIT_Q8) backlog = backlog / (credit >>> 8);
            // pick the line count from the backlog
            if (backlog > 2 * whole) begin
               cnt = 2 * whole;
            end else if (backlog > whole) begin
               cnt = whole;
               if (draw_jsum >= UNIT_Q16) begin
                  draw_jsum -= UNIT_Q16;
                  cnt++;
               end
            end else begin
               cnt = backlog;
            end
            start = ri;
            last = ri + cnt - 1;
            if (last > ring - 1) begin
               start = 0;
               last -= ring;
               wrap = 1'b1;
            end
            if (cnt == 0) begin
               rd_idx = ri;
               r.seg_start = LINE_W'(ri);
               r.seg_end   = LINE_W'(ri);
            end else begin
               nxt = last + 1;
               if (nxt > ring - 1) nxt -= ring;
               if (nxt < 0) nxt = 0;
               rd_idx = nxt % ring;
               add_credit(-UNIT_Q8);
               r.seg_start       = LINE_W'(start);
               r.seg_end         = LINE_W'(((last < 0) ? 0 : last) % ring);
               r.line_count      = LINE_W'(cnt);
               r.wrapped         = wrap;
               r.draw_ok         = 1'b1;
               r.backlog_warning = (backlog > WARN_RATIO * whole);
            end
         end
         CMD_SKIP: begin
            if (credit >= 2 * UNIT_Q8) begin
               add_credit(-UNIT_Q8);
               r.skip_now = 1'b1;
            end
         end
         default: ;
      endcase
      // credit status after the command
      pend = (credit < 0) ? 0 : (credit >>> 8);
      if (pend > 255) pend = 255;
      r.frames_pending = PEND_W'(pend);
      r.ready_res = (credit >= UNIT_Q8);
      return r;
   endfunction

   function automatic string show_result(srrm_result_type r);
      return $sformatf({"start=%0d end=%0d count=%0d first=%0d skipped=%0b wrapped=%0b ",
                        "draw_ok=%0b pending=%0d warn=%0b skip_now=%0b ready=%0b"},
                       r.seg_start, r.seg_end, r.line_count, r.first_part, r.line_skipped,
                       r.wrapped, r.draw_ok, r.frames_pending, r.backlog_warning,
                       r.skip_now, r.ready_res);
   endfunction

   // offer one command, wait for the transaction and queue its expected result
   task automatic send_item(input logic [1:0] cmd, input logic [12:0] lines,
                            input logic fixed, input srrm_result_type given);
      srrm_result_type want;
      csr_we <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, lines};
      do @(posedge clock); while (req_tready !== 1'b1);
      want = advance_ring(cmd, lines);
      if (fixed) want = given;
      pending_results.push_back(want);
      cmds_issued++;
   endtask

   // hold off new commands until every result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_seen != cmds_issued) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      case (idx)
         CSR_SCREEN_LINES: cfg_lines  = val[LINE_W-1:0];
         CSR_SCROLL_RATE:  cfg_rate   = val;
         CSR_JITTER:       cfg_jitter = val;
         CSR_FPF:          cfg_fpf    = val;
         default: ;
      endcase
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_count;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      srrm_result_type got;
      srrm_result_type want;
      string bad;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = srrm_result_type'(rsp_tdata[$bits(srrm_result_type)-1:0]);
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result transaction: %s", show_result(got));
         end else begin
            want = pending_results.pop_front();
            bad = "";
            if (got.seg_start !== want.seg_start) bad = {bad, " seg_start"};
            if (got.seg_end !== want.seg_end) bad = {bad, " seg_end"};
            if (got.line_count !== want.line_count) bad = {bad, " line_count"};
            if (got.first_part !== want.first_part) bad = {bad, " first_part"};
            if (got.line_skipped !== want.line_skipped) bad = {bad, " line_skipped"};
            if (got.wrapped !== want.wrapped) bad = {bad, " wrapped"};
            if (got.draw_ok !== want.draw_ok) bad = {bad, " draw_ok"};
            if (got.frames_pending !== want.frames_pending) bad = {bad, " frames_pending"};
            if (got.backlog_warning !== want.backlog_warning) bad = {bad, " backlog_warning"};
            if (got.skip_now !== want.skip_now) bad = {bad, " skip_now"};
            if (got.ready_res !== want.ready_res) bad = {bad, " ready_res"};
            if (bad != "") begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result %0d mismatch in%s\n  expected %s\n  actual   %s",
                           results_seen, bad, show_result(want), show_result(got));
            end
         end
      end
   end

   // bound the run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      int row, phase, seg, k, count, frame_pct, pick, ring_now;
      logic [1:0]  cmd;
      logic [12:0] lines;
      logic [15:0] lines_val, rate_val, jit_val, fpf_val;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      cfg_lines      = 13'd1000;
      cfg_rate       = '0;
      cfg_jitter     = '0;
      cfg_fpf        = 16'd256;
      wr_idx         = 0;
      rd_idx         = 0;
      feed_jsum      = 0;
      draw_jsum      = 0;
      credit         = 0;
      cmds_issued    = 0;
      results_seen   = 0;
      mismatch_count = 0;
      hold_request   = 1'b0;
      send_idle_pct  = 33;
      recv_stall_pct = 84;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (row = 0; row < PLAN_LEN; row++) begin
         if (PLAN[row].reg_write) begin
            drain_results();
            write_reg(PLAN[row].code, PLAN[row].value);
         end else begin
            send_item(PLAN[row].code, PLAN[row].value[12:0], PLAN[row].fixed,
                      PLAN[row].result);
         end
      end

      // random part: three flow-control phases, each with several register settings
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 84 : 0;
         recv_stall_pct = (phase == 0) ? 84 : (phase == 1) ? 33 : 0;
         for (seg = 0; seg < 6; seg++) begin
            drain_results();
            pick = $urandom_range(99);
            if (pick < 5) lines_val = 16'd0;
            else if (pick < 10) lines_val = 16'd1;
            else if (pick < 15) lines_val = 16'd8191;
            else if (pick < 45) lines_val = 16'($urandom_range(2, 64));
            else if (pick < 85) lines_val = 16'($urandom_range(65, 2000));
            else lines_val = 16'($urandom_range(2001, 8191));
            pick = $urandom_range(99);
            if (pick < 10) rate_val = 16'd0;
            else if (pick < 40) rate_val = 16'($urandom_range(0, 'h800));
            else if (pick < 80) rate_val = 16'($urandom_range(0, 'h4000));
            else rate_val = 16'($urandom_range(0, 'hFFFF));
            pick = $urandom_range(99);
            if (pick < 20) jit_val = 16'd0;
            else if (pick < 40) jit_val = 16'hFFFF;
            else if (pick < 60) jit_val = 16'($urandom_range('h8000, 'hFFFF));
            else jit_val = 16'($urandom_range(0, 'hFFFF));
            pick = $urandom_range(99);
            if (pick < 15) fpf_val = 16'd0;
            else if (pick < 25) fpf_val = 16'h0100;
            else fpf_val = 16'($urandom_range(0, 'h140));
            frame_pct = 45;
            count = 64;
            // starve the credit so it goes negative
            if (phase == 1 && seg == 0) begin
               fpf_val = 16'd0;
               rate_val = 16'($urandom_range('h100, 'h800));
               frame_pct = 10;
            end
            // flood the credit up to its ceiling at the very end
            if (phase == 2 && seg == 5) begin
               fpf_val = 16'hFFFF;
               frame_pct = 90;
               count = 200;
            end
            write_reg(CSR_SCREEN_LINES, lines_val);
            write_reg(CSR_SCROLL_RATE, rate_val);
            write_reg(CSR_JITTER, jit_val);
            write_reg(CSR_FPF, fpf_val);
            if (phase == 2 && seg == 1) hold_request = 1'b1;
            for (k = 0; k < count; k++) begin
               pick = $urandom_range(99);
               if (pick < frame_pct) begin
                  cmd = CMD_FRAME;
               end else begin
                  pick = $urandom_range(9);
                  cmd = (pick < 6) ? CMD_DRAW : (pick < 9) ? CMD_SKIP : CMD_UNKNOWN;
               end
               ring_now = (cfg_lines == 0) ? 1 : int'(cfg_lines);
               pick = $urandom_range(99);
               if (pick < 15) lines = 13'($urandom_range(0, 8191));
               else if (pick < 35) lines = 13'($urandom_range(0, 8));
               else lines = 13'($urandom_range(0, ring_now));
               send_item(cmd, lines, 1'b0, NO_FIELDS);
            end
         end
      end

      // let the last results arrive and watch for stray ones
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
